// ===== rtl/core/sbv_pkg.sv =====
// Shared sizes, entry formats, codes and address helpers of the sparse brick voxel store.
package sbv_pkg;

    localparam int BOTTOM_SIDE       = 4;
    localparam int TOP_SIDE          = 4;
    localparam int MAX_ROOT_ENTRIES  = 4096;
    localparam int TOP_POOL_SLOTS    = 64;
    localparam int BOTTOM_POOL_SLOTS = 1024;
    localparam int VOXEL_BITS        = 8;

    localparam int SPAN   = TOP_SIDE * BOTTOM_SIDE;
    localparam int BCELLS = BOTTOM_SIDE * BOTTOM_SIDE * BOTTOM_SIDE;
    localparam int TCELLS = TOP_SIDE * TOP_SIDE * TOP_SIDE;

    localparam int RI_W = (MAX_ROOT_ENTRIES > 1) ? $clog2(MAX_ROOT_ENTRIES) : 1;
    localparam int TS_W = (TOP_POOL_SLOTS > 1) ? $clog2(TOP_POOL_SLOTS) : 1;
    localparam int BS_W = (BOTTOM_POOL_SLOTS > 1) ? $clog2(BOTTOM_POOL_SLOTS) : 1;
    localparam int TC_W = $clog2(TCELLS);
    localparam int BC_W = $clog2(BCELLS);
    localparam int TA_W = $clog2(TOP_POOL_SLOTS * TCELLS);
    localparam int VA_W = $clog2(BOTTOM_POOL_SLOTS * BCELLS);
    localparam int BP_CW = $clog2(BOTTOM_POOL_SLOTS + 1);
    localparam int RV_W = (TS_W > VOXEL_BITS) ? TS_W : VOXEL_BITS;
    localparam int TV_W = (BS_W > VOXEL_BITS) ? BS_W : VOXEL_BITS;
    localparam int CNT_W0 = (RI_W > TC_W) ? RI_W : TC_W;
    localparam int CNT_W = (CNT_W0 > BC_W) ? CNT_W0 : BC_W;

    localparam int CFG_W    = 5;
    localparam int COORD_W  = 11;
    localparam int FIELD_W  = 8;
    localparam int GRID_MAX = 16;
    localparam int RIC_W    = COORD_W + 2 * CFG_W;

    localparam logic [1:0] CFG_GRID_X = 2'd0;
    localparam logic [1:0] CFG_GRID_Y = 2'd1;
    localparam logic [1:0] CFG_GRID_Z = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OUTSIDE   = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    typedef enum logic [1:0] {
        MODE_READ,
        MODE_WRITE,
        MODE_COALESCE,
        MODE_NOP
    } t_mode;

    typedef struct packed {
        logic            dirty;
        logic            uniform;
        logic [RV_W-1:0] val;
    } t_root_ent;

    typedef struct packed {
        logic            dirty;
        logic            uniform;
        logic [TV_W-1:0] val;
    } t_top_ent;

    typedef struct packed {
        logic                  root_we;
        logic [RI_W-1:0]       root_addr;
        t_root_ent             root_wd;
        logic                  top_we;
        logic [TA_W-1:0]       top_addr;
        t_top_ent              top_wd;
        logic                  vox_we;
        logic [VA_W-1:0]       vox_addr;
        logic [VOXEL_BITS-1:0] vox_wd;
    } t_mem_req;

    typedef struct packed {
        logic            alloc;
        logic            free;
        logic [BS_W-1:0] free_slot;
    } t_bp_req;

    function automatic logic [TA_W-1:0] top_addr(input logic [TS_W-1:0] s,
                                                 input logic [TC_W-1:0] c);
        return TA_W'(s) * TA_W'(TCELLS) + TA_W'(c);
    endfunction

    function automatic logic [VA_W-1:0] vox_addr(input logic [BS_W-1:0] s,
                                                 input logic [BC_W-1:0] c);
        return VA_W'(s) * VA_W'(BCELLS) + VA_W'(c);
    endfunction

endpackage

// ===== rtl/core/sparse_brick_voxel_store_unit.sv =====
// Sparse brick voxel store: request sequencer over the root, top and voxel memories.
//
// After reset the block clears every root table entry to uniform air and accepts no
// request until then. A request runs alone through a sequencer that walks the three
// single-port memories, one dependent lookup per cycle: a read ends at the first uniform
// root entry or top cell or else reads the voxel, a write that hits an existing bottom
// brick writes the voxel directly, one that splits a bottom brick first fills a new brick
// with the old value, and one that also splits the top brick fills a new top brick first
// (one fill pass per new brick). A coalesce scans every allocated top brick cell by cell,
// reading all voxels of each dirty split cell to check them, then walks all 4096 root
// entries. The finished result sits in an output register while the next request is taken.
module sparse_brick_voxel_store_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // coord_x, coord_y, coord_z, write_value
    input  logic [1:0]  i_s_tuser,  // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // read_value, status
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    import sbv_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_IDX, S_RROOT, S_ROOT, S_CELL, S_VOX, S_FILLT, S_BALLOC,
        S_BWAIT, S_FILLB, S_WVOX, S_C_SLOT, S_C_RD, S_C_CELL, S_C_VSCAN,
        S_C2_RD, S_C2_ROOT, S_C2_WR, S_RES
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_gx, r_gy, r_gz;
    logic [2*CFG_W-1:0]    r_gxy;
    t_mode                 r_mode;
    logic [COORD_W-1:0]    r_x, r_y, r_z;
    logic [VOXEL_BITS-1:0] r_wv;
    logic [RI_W-1:0]       r_ri;
    logic [TC_W-1:0]       r_mid;
    logic [BC_W-1:0]       r_loc;
    logic [TS_W-1:0]       r_ts;
    logic [BS_W-1:0]       r_b;
    logic [VOXEL_BITS-1:0] r_old;
    logic [CNT_W-1:0]      r_cnt;
    logic [TOP_POOL_SLOTS-1:0] r_top_used;
    logic [TS_W-1:0]       r_cs;
    logic [TC_W-1:0]       r_cc;
    logic [BC_W:0]         r_vi;
    logic [VOXEL_BITS-1:0] r_first;
    logic                  r_same;
    logic                  r_ok;
    logic [VOXEL_BITS-1:0] r_sfirst;
    logic [TOP_POOL_SLOTS-1:0] r_sum_ok;
    logic [VOXEL_BITS-1:0] r_sum_val [TOP_POOL_SLOTS];
    logic [VOXEL_BITS-1:0] r_sval;
    logic                  r_sok;
    logic [FIELD_W-1:0]    r_res_val;
    logic [1:0]            r_res_st;
    logic                  r_ov;
    logic [15:0]           r_od;

    t_mem_req              mem_req;
    t_root_ent             root_q;
    t_top_ent              top_q;
    logic [VOXEL_BITS-1:0] vox_q;
    t_bp_req               bp_req;
    logic                  bp_avail;
    logic [BS_W-1:0]       bp_slot;

    logic [CFG_W-1:0]      cfg_v;
    logic                  top_any;
    logic [TS_W-1:0]       top_idx;
    logic [COORD_W-1:0]    ux, uy, uz;
    logic                  oob;
    logic [RIC_W-1:0]      ri_c;
    logic [TC_W-1:0]       mid_c;
    logic [BC_W-1:0]       loc_c;
    logic                  scan_need;
    logic                  scan_end;
    logic                  same_fin;
    logic                  c_fin;
    logic                  c_uni;
    logic [VOXEL_BITS-1:0] c_val;
    logic                  ok_new;
    logic [VOXEL_BITS-1:0] sum_first;
    logic [TS_W-1:0]       rq_slot;
    logic                  c2_merge;

    sbv_mems u_mems (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_root_q (root_q),
        .o_top_q  (top_q),
        .o_vox_q  (vox_q)
    );

    sbv_bpool u_bpool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bp_req),
        .o_avail (bp_avail),
        .o_slot  (bp_slot)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;

    always_comb begin
        cfg_v = i_cfg_data;
        if (cfg_v == '0) begin
            cfg_v = CFG_W'(1);
        end else if (cfg_v > CFG_W'(GRID_MAX)) begin
            cfg_v = CFG_W'(GRID_MAX);
        end
    end

    always_comb begin
        top_any = 1'b0;
        top_idx = '0;
        for (int i = TOP_POOL_SLOTS - 1; i >= 0; i--) begin
            if (!r_top_used[i]) begin
                top_any = 1'b1;
                top_idx = TS_W'(i);
            end
        end
    end

    always_comb begin
        ux    = {1'b0, r_x[COORD_W-2:0]};
        uy    = {1'b0, r_y[COORD_W-2:0]};
        uz    = {1'b0, r_z[COORD_W-2:0]};
        ri_c  = RIC_W'(uz / SPAN) * RIC_W'(r_gxy) + RIC_W'(uy / SPAN) * RIC_W'(r_gx)
              + RIC_W'(ux / SPAN);
        oob   = r_x[COORD_W-1] || r_y[COORD_W-1] || r_z[COORD_W-1]
              || (ux >= COORD_W'(r_gx) * COORD_W'(SPAN))
              || (uy >= COORD_W'(r_gy) * COORD_W'(SPAN))
              || (uz >= COORD_W'(r_gz) * COORD_W'(SPAN))
              || (ri_c >= RIC_W'(MAX_ROOT_ENTRIES));
        mid_c = TC_W'(((uz / BOTTOM_SIDE) % TOP_SIDE) * COORD_W'(TOP_SIDE * TOP_SIDE)
              + ((uy / BOTTOM_SIDE) % TOP_SIDE) * COORD_W'(TOP_SIDE)
              + (ux / BOTTOM_SIDE) % TOP_SIDE);
        loc_c = BC_W'((uz % BOTTOM_SIDE) * COORD_W'(BOTTOM_SIDE * BOTTOM_SIDE)
              + (uy % BOTTOM_SIDE) * COORD_W'(BOTTOM_SIDE)
              + ux % BOTTOM_SIDE);
    end

    assign rq_slot   = root_q.val[TS_W-1:0];
    assign scan_need = top_q.dirty && !top_q.uniform;
    assign scan_end  = (r_vi == (BC_W+1)'(BCELLS));
    assign same_fin  = r_same && (vox_q == r_first);
    assign c2_merge  = !root_q.uniform && r_sok;

    always_comb begin
        c_fin = 1'b0;
        c_uni = top_q.uniform;
        c_val = top_q.val[VOXEL_BITS-1:0];
        if (r_state == S_C_CELL && !scan_need) begin
            c_fin = 1'b1;
        end else if (r_state == S_C_VSCAN && scan_end) begin
            c_fin = 1'b1;
            c_uni = same_fin;
            c_val = same_fin ? r_first : VOXEL_BITS'(r_b);
        end
        ok_new    = (r_cc == '0) ? c_uni : (r_ok && c_uni && (c_val == r_sfirst));
        sum_first = (r_cc == '0) ? c_val : r_sfirst;
    end

    always_comb begin
        mem_req           = '0;
        mem_req.root_addr = r_ri;
        mem_req.top_addr  = top_addr(r_ts, r_mid);
        mem_req.vox_addr  = vox_addr(r_b, r_loc);
        bp_req            = '0;
        bp_req.free_slot  = r_b;
        case (r_state)
            S_CLR: begin
                mem_req.root_we   = 1'b1;
                mem_req.root_addr = r_cnt[RI_W-1:0];
                mem_req.root_wd   = '{dirty: 1'b0, uniform: 1'b1, val: '0};
            end
            S_ROOT: begin
                mem_req.top_addr = top_addr(rq_slot, r_mid);
            end
            S_CELL: begin
                mem_req.vox_addr = vox_addr(top_q.val[BS_W-1:0], r_loc);
            end
            S_FILLT: begin
                mem_req.top_we   = 1'b1;
                mem_req.top_addr = top_addr(r_ts, r_cnt[TC_W-1:0]);
                mem_req.top_wd   = '{dirty: 1'b0, uniform: 1'b1, val: TV_W'(r_old)};
            end
            S_BALLOC: begin
                bp_req.alloc = 1'b1;
            end
            S_FILLB: begin
                mem_req.vox_we   = 1'b1;
                mem_req.vox_addr = vox_addr(r_b, r_cnt[BC_W-1:0]);
                mem_req.vox_wd   = r_old;
            end
            S_WVOX: begin
                mem_req.vox_we  = 1'b1;
                mem_req.vox_wd  = r_wv;
                mem_req.top_we  = 1'b1;
                mem_req.top_wd  = '{dirty: 1'b1, uniform: 1'b0, val: TV_W'(r_b)};
                mem_req.root_we = 1'b1;
                mem_req.root_wd = '{dirty: 1'b1, uniform: 1'b0, val: RV_W'(r_ts)};
            end
            S_C_RD: begin
                mem_req.top_addr = top_addr(r_cs, r_cc);
            end
            S_C_CELL: begin
                mem_req.top_addr = top_addr(r_cs, r_cc);
                if (scan_need) begin
                    mem_req.vox_addr = vox_addr(top_q.val[BS_W-1:0], '0);
                end else begin
                    mem_req.top_we = top_q.dirty;
                    mem_req.top_wd = '{dirty: 1'b0, uniform: top_q.uniform, val: top_q.val};
                end
            end
            S_C_VSCAN: begin
                mem_req.top_addr = top_addr(r_cs, r_cc);
                if (!scan_end) begin
                    mem_req.vox_addr = vox_addr(r_b, r_vi[BC_W-1:0]);
                end else begin
                    mem_req.top_we = 1'b1;
                    mem_req.top_wd = same_fin ?
                        '{dirty: 1'b0, uniform: 1'b1, val: TV_W'(r_first)} :
                        '{dirty: 1'b0, uniform: 1'b0, val: TV_W'(r_b)};
                    bp_req.free    = same_fin;
                end
            end
            S_C2_RD: begin
                mem_req.root_addr = r_cnt[RI_W-1:0];
            end
            S_C2_ROOT: begin
                mem_req.root_addr = r_cnt[RI_W-1:0];
            end
            S_C2_WR: begin
                mem_req.root_addr = r_cnt[RI_W-1:0];
                mem_req.root_we   = root_q.dirty;
                mem_req.root_wd   = c2_merge ?
                    '{dirty: 1'b0, uniform: 1'b1, val: RV_W'(r_sval)} :
                    '{dirty: 1'b0, uniform: root_q.uniform, val: root_q.val};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_gxy  <= (2*CFG_W)'(r_gx) * (2*CFG_W)'(r_gy);
        r_sval <= r_sum_val[rq_slot];
        r_sok  <= r_sum_ok[rq_slot];
        if (c_fin && r_cc == TC_W'(TCELLS - 1)) begin
            r_sum_val[r_cs] <= sum_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_cnt      <= '0;
            r_gx       <= CFG_W'(1);
            r_gy       <= CFG_W'(1);
            r_gz       <= CFG_W'(1);
            r_top_used <= '0;
            r_sum_ok   <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_X: r_gx <= cfg_v;
                    CFG_GRID_Y: r_gy <= cfg_v;
                    CFG_GRID_Z: r_gz <= cfg_v;
                    default: begin
                    end
                endcase
            end
            if (r_ov && i_m_tready && r_state != S_RES) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MAX_ROOT_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_mode  <= t_mode'(i_s_tuser);
                        r_x     <= i_s_tdata[10:0];
                        r_y     <= i_s_tdata[21:11];
                        r_z     <= i_s_tdata[32:22];
                        r_wv    <= VOXEL_BITS'(i_s_tdata[40:33]);
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_res_val <= '0;
                    r_res_st  <= ST_OK;
                    r_ri      <= ri_c[RI_W-1:0];
                    r_mid     <= mid_c;
                    r_loc     <= loc_c;
                    r_cs      <= '0;
                    case (r_mode)
                        MODE_NOP: r_state <= S_RES;
                        MODE_COALESCE: r_state <= S_C_SLOT;
                        default: begin
                            if (oob) begin
                                r_res_st <= ST_OUTSIDE;
                                r_state  <= S_RES;
                            end else begin
                                r_state <= S_RROOT;
                            end
                        end
                    endcase
                end
                S_RROOT: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_ts <= rq_slot;
                    if (r_mode == MODE_READ) begin
                        if (root_q.uniform) begin
                            r_res_val <= FIELD_W'(root_q.val[VOXEL_BITS-1:0]);
                            r_state   <= S_RES;
                        end else begin
                            r_state <= S_CELL;
                        end
                    end else if (root_q.uniform) begin
                        if (top_any && bp_avail) begin
                            r_ts                <= top_idx;
                            r_top_used[top_idx] <= 1'b1;
                            r_old               <= root_q.val[VOXEL_BITS-1:0];
                            r_cnt               <= '0;
                            r_state             <= S_FILLT;
                        end else begin
                            r_res_st <= ST_EXHAUSTED;
                            r_state  <= S_RES;
                        end
                    end else begin
                        r_state <= S_CELL;
                    end
                end
                S_CELL: begin
                    r_b <= top_q.val[BS_W-1:0];
                    if (r_mode == MODE_READ) begin
                        if (top_q.uniform) begin
                            r_res_val <= FIELD_W'(top_q.val[VOXEL_BITS-1:0]);
                            r_state   <= S_RES;
                        end else begin
                            r_state <= S_VOX;
                        end
                    end else if (top_q.uniform) begin
                        if (bp_avail) begin
                            r_old   <= top_q.val[VOXEL_BITS-1:0];
                            r_state <= S_BALLOC;
                        end else begin
                            r_res_st <= ST_EXHAUSTED;
                            r_state  <= S_RES;
                        end
                    end else begin
                        r_state <= S_WVOX;
                    end
                end
                S_VOX: begin
                    r_res_val <= FIELD_W'(vox_q);
                    r_state   <= S_RES;
                end
                S_FILLT: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(TCELLS - 1)) begin
                        r_state <= S_BALLOC;
                    end
                end
                S_BALLOC: begin
                    r_state <= S_BWAIT;
                end
                S_BWAIT: begin
                    r_b     <= bp_slot;
                    r_cnt   <= '0;
                    r_state <= S_FILLB;
                end
                S_FILLB: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(BCELLS - 1)) begin
                        r_state <= S_WVOX;
                    end
                end
                S_WVOX: begin
                    r_state <= S_RES;
                end
                S_C_SLOT: begin
                    r_cc <= '0;
                    if (r_top_used[r_cs]) begin
                        r_state <= S_C_RD;
                    end else if (r_cs == TS_W'(TOP_POOL_SLOTS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_C2_RD;
                    end else begin
                        r_cs <= r_cs + TS_W'(1);
                    end
                end
                S_C_RD: begin
                    r_state <= S_C_CELL;
                end
                S_C_CELL: begin
                    if (scan_need) begin
                        r_b     <= top_q.val[BS_W-1:0];
                        r_vi    <= (BC_W+1)'(1);
                        r_state <= S_C_VSCAN;
                    end
                end
                S_C_VSCAN: begin
                    if (!scan_end) begin
                        r_vi <= r_vi + (BC_W+1)'(1);
                        if (r_vi == (BC_W+1)'(1)) begin
                            r_first <= vox_q;
                            r_same  <= 1'b1;
                        end else if (vox_q != r_first) begin
                            r_same <= 1'b0;
                        end
                    end
                end
                S_C2_RD: begin
                    r_state <= S_C2_ROOT;
                end
                S_C2_ROOT: begin
                    r_state <= S_C2_WR;
                end
                S_C2_WR: begin
                    if (root_q.dirty && c2_merge) begin
                        r_top_used[rq_slot] <= 1'b0;
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MAX_ROOT_ENTRIES - 1)) begin
                        r_state <= S_RES;
                    end else begin
                        r_state <= S_C2_RD;
                    end
                end
                S_RES: begin
                    if (!r_ov || i_m_tready) begin
                        r_ov    <= 1'b1;
                        r_od    <= {6'b0, r_res_st, r_res_val};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (c_fin) begin
                r_ok     <= ok_new;
                r_sfirst <= sum_first;
                if (r_cc == TC_W'(TCELLS - 1)) begin
                    r_sum_ok[r_cs] <= ok_new;
                    if (r_cs == TS_W'(TOP_POOL_SLOTS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_C2_RD;
                    end else begin
                        r_cs    <= r_cs + TS_W'(1);
                        r_state <= S_C_SLOT;
                    end
                end else begin
                    r_cc    <= r_cc + TC_W'(1);
                    r_state <= S_C_RD;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILLT) |-> r_top_used[r_ts]) else $error("fill of an unowned top slot");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[9:8] != 2'd3)) else $error("bad status code");
    a_wr_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WVOX) |=> (r_state == S_RES)) else $error("write did not finish");
    a_free_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bp_req.free |-> (r_state == S_C_VSCAN)) else $error("bottom slot freed outside merge");
`endif

endmodule

// ===== rtl/core/sbv_mems.sv =====
// Root table, top brick pool and voxel pool memories, one port each, registered read.
module sbv_mems (
    input  logic                         i_clk,
    input  sbv_pkg::t_mem_req            i_req,
    output sbv_pkg::t_root_ent           o_root_q,
    output sbv_pkg::t_top_ent            o_top_q,
    output logic [sbv_pkg::VOXEL_BITS-1:0] o_vox_q
);
    import sbv_pkg::*;

    t_root_ent             r_root_mem [MAX_ROOT_ENTRIES];
    t_top_ent              r_top_mem  [TOP_POOL_SLOTS * TCELLS];
    logic [VOXEL_BITS-1:0] r_vox_mem  [BOTTOM_POOL_SLOTS * BCELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.root_we) begin
            r_root_mem[i_req.root_addr] <= i_req.root_wd;
        end
        o_root_q <= r_root_mem[i_req.root_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.top_we) begin
            r_top_mem[i_req.top_addr] <= i_req.top_wd;
        end
        o_top_q <= r_top_mem[i_req.top_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.vox_we) begin
            r_vox_mem[i_req.vox_addr] <= i_req.vox_wd;
        end
        o_vox_q <= r_vox_mem[i_req.vox_addr];
    end

endmodule

// ===== rtl/core/sbv_bpool.sv =====
// Bottom brick slot allocator: fresh-slot counter plus a stack of freed slots.
module sbv_bpool (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sbv_pkg::t_bp_req         i_req,
    output logic                     o_avail,
    output logic [sbv_pkg::BS_W-1:0] o_slot
);
    import sbv_pkg::*;

    logic [BS_W-1:0]  r_stack [BOTTOM_POOL_SLOTS];
    logic [BP_CW-1:0] r_hw;
    logic [BP_CW-1:0] r_sp;
    logic [BS_W-1:0]  r_rd;
    logic [BS_W-1:0]  r_hw_snap;
    logic             r_from_stack;
    logic [BP_CW-1:0] sp_dec;

    assign sp_dec  = r_sp - BP_CW'(1);
    assign o_avail = (r_hw != BP_CW'(BOTTOM_POOL_SLOTS)) || (r_sp != '0);
    assign o_slot  = r_from_stack ? r_rd : r_hw_snap;

    always_ff @(posedge i_clk) begin
        if (i_req.free) begin
            r_stack[r_sp[BS_W-1:0]] <= i_req.free_slot;
        end
        r_rd <= r_stack[sp_dec[BS_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw         <= '0;
            r_sp         <= '0;
            r_from_stack <= 1'b0;
            r_hw_snap    <= '0;
        end else begin
            if (i_req.alloc) begin
                r_from_stack <= (r_sp != '0);
                r_hw_snap    <= r_hw[BS_W-1:0];
                if (r_sp != '0) begin
                    r_sp <= sp_dec;
                end else begin
                    r_hw <= r_hw + BP_CW'(1);
                end
            end
            if (i_req.free) begin
                r_sp <= r_sp + BP_CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_alloc_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.alloc |-> o_avail) else $error("bottom slot taken from an empty pool");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.alloc && i_req.free)) else $error("bottom alloc and free together");
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= r_hw) else $error("more freed bottom slots than ever taken");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the sparse brick voxel store: directed table, pool-exhaustion run and random traffic.
module testbench;
    import sbv_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;  // coord_x, coord_y, coord_z, write_value
    logic [1:0]  i_s_tuser = '0;  // mode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;       // read_value, status
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [4:0]  i_cfg_data = '0;

    sparse_brick_voxel_store_unit i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        logic [7:0] rv;
        logic [1:0] st;
    } t_answer;

    typedef struct {
        t_mode mode;
        int    x, y, z, wv;
        bit    typed;
        int    rv, st;
    } t_row;

    // voxel store image
    int unsigned gx, gy, gz;
    bit          root_uni [MAX_ROOT_ENTRIES];
    int unsigned root_val [MAX_ROOT_ENTRIES];
    bit          cell_uni [TOP_POOL_SLOTS*TCELLS];
    int unsigned cell_val [TOP_POOL_SLOTS*TCELLS];
    logic [7:0]  voxels   [BOTTOM_POOL_SLOTS*BCELLS];
    bit          top_free [TOP_POOL_SLOTS];
    bit          bot_free [BOTTOM_POOL_SLOTS];
    bit          root_dty [MAX_ROOT_ENTRIES];
    bit          cell_dty [TOP_POOL_SLOTS*TCELLS];

    t_answer pending_answers[$];
    int      n_fail = 0;
    int      n_results = 0;
    int      cycles = 0;
    int      burst_left = 0;

    function automatic int first_free_top();
        for (int i = 0; i < TOP_POOL_SLOTS; i++) if (top_free[i]) return i;
        return -1;
    endfunction

    function automatic int first_free_bottom();
        for (int i = 0; i < BOTTOM_POOL_SLOTS; i++) if (bot_free[i]) return i;
        return -1;
    endfunction

    function automatic void merge_dirty_bricks();
        int unsigned b, s, first;
        bit same;
        for (int e = 0; e < TOP_POOL_SLOTS*TCELLS; e++) begin
            if (!cell_dty[e] || top_free[e/TCELLS] || cell_uni[e]) continue;
            b = cell_val[e];
            first = voxels[b*BCELLS];
            same = 1;
            for (int i = 1; i < BCELLS; i++) if (voxels[b*BCELLS+i] != first) same = 0;
            if (same) begin
                bot_free[b] = 1;
                cell_uni[e] = 1;
                cell_val[e] = first;
            end
        end
        for (int r = 0; r < MAX_ROOT_ENTRIES; r++) begin
            if (!root_dty[r] || root_uni[r]) continue;
            s = root_val[r];
            first = cell_val[s*TCELLS];
            same = 1;
            for (int i = 0; i < TCELLS; i++)
                if (!cell_uni[s*TCELLS+i] || cell_val[s*TCELLS+i] != first) same = 0;
            if (same) begin
                top_free[s] = 1;
                root_uni[r] = 1;
                root_val[r] = first;
            end
        end
        root_dty = '{default: 0};
        cell_dty = '{default: 0};
    endfunction

    function automatic t_answer voxel_access(t_mode mode, logic signed [10:0] sx,
                                             logic signed [10:0] sy, logic signed [10:0] sz,
                                             logic [7:0] wv);
        t_answer a;
        int x, y, z, ts, bs;
        int unsigned ri, mid, loc, e, b;
        x = sx; y = sy; z = sz;
        a.rv = '0;
        a.st = ST_OK;
        if (mode == MODE_COALESCE) begin
            merge_dirty_bricks();
            return a;
        end
        if (mode == MODE_NOP) return a;
        if (x < 0 || y < 0 || z < 0 || x >= gx*SPAN || y >= gy*SPAN || z >= gz*SPAN) begin
            a.st = ST_OUTSIDE;
            return a;
        end
        ri = (z/SPAN)*gx*gy + (y/SPAN)*gx + x/SPAN;
        if (ri >= MAX_ROOT_ENTRIES) begin
            a.st = ST_OUTSIDE;
            return a;
        end
        mid = ((z/BOTTOM_SIDE)%TOP_SIDE)*TOP_SIDE*TOP_SIDE
            + ((y/BOTTOM_SIDE)%TOP_SIDE)*TOP_SIDE + (x/BOTTOM_SIDE)%TOP_SIDE;
        loc = (z%BOTTOM_SIDE)*BOTTOM_SIDE*BOTTOM_SIDE + (y%BOTTOM_SIDE)*BOTTOM_SIDE
            + x%BOTTOM_SIDE;
        if (mode == MODE_READ) begin
            if (root_uni[ri]) a.rv = 8'(root_val[ri]);
            else begin
                e = root_val[ri]*TCELLS + mid;
                a.rv = cell_uni[e] ? 8'(cell_val[e]) : voxels[cell_val[e]*BCELLS + loc];
            end
            return a;
        end
        if (root_uni[ri]) begin
            ts = first_free_top();
            bs = first_free_bottom();
            if (ts < 0 || bs < 0) begin
                a.st = ST_EXHAUSTED;
                return a;
            end
            top_free[ts] = 0;
            for (int i = 0; i < TCELLS; i++) begin
                cell_uni[ts*TCELLS+i] = 1;
                cell_val[ts*TCELLS+i] = root_val[ri];
            end
            root_uni[ri] = 0;
            root_val[ri] = ts;
        end
        e = root_val[ri]*TCELLS + mid;
        if (cell_uni[e]) begin
            bs = first_free_bottom();
            if (bs < 0) begin
                a.st = ST_EXHAUSTED;
                return a;
            end
            bot_free[bs] = 0;
            for (int i = 0; i < BCELLS; i++) voxels[bs*BCELLS+i] = 8'(cell_val[e]);
            cell_uni[e] = 0;
            cell_val[e] = bs;
        end
        b = cell_val[e];
        voxels[b*BCELLS + loc] = wv;
        root_dty[ri] = 1;
        cell_dty[e] = 1;
        return a;
    endfunction

    task automatic set_grid_reg(logic [1:0] idx, logic [4:0] value);
        int unsigned v;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        v = (value < 1) ? 1 : (value > GRID_MAX) ? GRID_MAX : value;
        if (idx == CFG_GRID_X) gx = v;
        else if (idx == CFG_GRID_Y) gy = v;
        else if (idx == CFG_GRID_Z) gz = v;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_grid(logic [4:0] vx, logic [4:0] vy, logic [4:0] vz);
        wait_idle();
        set_grid_reg(CFG_GRID_X, vx);
        set_grid_reg(CFG_GRID_Y, vy);
        set_grid_reg(CFG_GRID_Z, vz);
    endtask

    task automatic send_request(t_mode mode, int x, int y, int z, int wv,
                                bit typed = 0, int rv = 0, int st = 0);
        int gap;
        t_answer a;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {7'd0, wv[7:0], z[10:0], y[10:0], x[10:0]};
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        a = voxel_access(mode, x[10:0], y[10:0], z[10:0], wv[7:0]);
        if (typed) begin
            a.rv = 8'(rv);
            a.st = 2'(st);
        end
        pending_answers.push_back(a);
    endtask

    task automatic random_phase(int n);
        int x, y, z, wv, pick;
        t_mode mode;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            mode = (pick < 40) ? MODE_READ : (pick < 93) ? MODE_WRITE :
                   (pick < 97) ? MODE_COALESCE : MODE_NOP;
            if ($urandom_range(0, 99) < 85) begin
                x = $urandom_range(0, gx*SPAN - 1);
                y = $urandom_range(0, gy*SPAN - 1);
                z = $urandom_range(0, gz*SPAN - 1);
            end else begin
                x = $signed(11'($urandom()));
                y = $signed(11'($urandom()));
                z = $signed(11'($urandom()));
            end
            pick = $urandom_range(0, 9);
            wv = (pick < 4) ? 0 : (pick < 7) ? $urandom_range(1, 3) : $urandom_range(0, 255);
            send_request(mode, x, y, z, wv);
        end
    endtask

    // receiver: randomly switching stall patterns plus one long hold-off
    int  ready_hold = 0;
    int  ready_mode = 0;
    bit  hold_done = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles % 150 == 0) ready_mode <= $urandom_range(0, 2);
        if (!hold_done && n_results == 40) begin
            hold_done  <= 1'b1;
            ready_hold <= 400;
            i_m_tready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_m_tready <= (ready_hold == 1);
        end else if (ready_mode == 0) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results <= n_results + 1;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_m_tdata);
                n_fail <= n_fail + 1;
            end else begin
                a = pending_answers.pop_front();
                if (o_m_tdata[7:0] !== a.rv || o_m_tdata[9:8] !== a.st) begin
                    $display("%0t: mismatch expected rv=%0d st=%0d actual rv=%0d st=%0d",
                             $time, a.rv, a.st, o_m_tdata[7:0], o_m_tdata[9:8]);
                    n_fail <= n_fail + 1;
                end
            end
        end
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    t_row directed[] = '{
        '{MODE_READ,     0,     0,     0,     0,   1, 0,   ST_OK},
        '{MODE_READ,     -1,    0,     0,     0,   1, 0,   ST_OUTSIDE},
        '{MODE_READ,     16,    0,     0,     0,   1, 0,   ST_OUTSIDE},
        '{MODE_READ,     1023,  1023,  1023,  0,   1, 0,   ST_OUTSIDE},
        '{MODE_READ,     -1024, -1024, -1024, 0,   1, 0,   ST_OUTSIDE},
        '{MODE_WRITE,    15,    15,    15,    255, 1, 0,   ST_OK},
        '{MODE_READ,     15,    15,    15,    0,   1, 255, ST_OK},
        '{MODE_READ,     14,    15,    15,    0,   1, 0,   ST_OK},
        '{MODE_WRITE,    0,     0,     0,     0,   1, 0,   ST_OK},
        '{MODE_WRITE,    -1024, 0,     0,     7,   1, 0,   ST_OUTSIDE},
        '{MODE_WRITE,    0,     1023,  0,     7,   1, 0,   ST_OUTSIDE},
        '{MODE_NOP,      1023,  -1024, 5,     255, 1, 0,   ST_OK},
        '{MODE_COALESCE, 0,     0,     0,     0,   1, 0,   ST_OK},
        '{MODE_READ,     15,    15,    15,    0,   1, 255, ST_OK},
        '{MODE_WRITE,    15,    15,    15,    0,   1, 0,   ST_OK},
        '{MODE_COALESCE, 0,     0,     0,     0,   1, 0,   ST_OK},
        '{MODE_READ,     15,    15,    15,    0,   1, 0,   ST_OK},
        '{MODE_WRITE,    5,     6,     7,     170, 1, 0,   ST_OK},
        '{MODE_READ,     5,     6,     7,     0,   1, 170, ST_OK},
        '{MODE_READ,     4,     6,     7,     0,   0, 0,   ST_OK},
        '{MODE_WRITE,    12,    1,     9,     1,   0, 0,   ST_OK},
        '{MODE_READ,     12,    1,     9,     0,   0, 0,   ST_OK}
    };

    initial begin
        gx = 1; gy = 1; gz = 1;
        root_uni = '{default: 1};
        root_val = '{default: 0};
        cell_uni = '{default: 0};
        cell_val = '{default: 0};
        voxels   = '{default: 0};
        top_free = '{default: 1};
        bot_free = '{default: 1};
        root_dty = '{default: 0};
        cell_dty = '{default: 0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_grid_reg(CFG_GRID_X, 5'd1);
        set_grid_reg(CFG_GRID_Y, 5'd1);
        set_grid_reg(CFG_GRID_Z, 5'd1);
        set_grid_reg(2'd3, 5'd9);
        foreach (directed[i])
            send_request(directed[i].mode, directed[i].x, directed[i].y, directed[i].z,
                         directed[i].wv, directed[i].typed, directed[i].rv, directed[i].st);

        // run the top brick pool dry, one new root entry per request
        set_grid(5'd16, 5'd16, 5'd16);
        for (int k = 0; k < 70; k++)
            send_request(MODE_WRITE, (k%16)*SPAN + 3, ((k/16)%16)*SPAN, 63, 0);
        send_request(MODE_COALESCE, 0, 0, 0, 0);

        set_grid(5'd2, 5'd2, 5'd2);
        random_phase(200);
        send_request(MODE_COALESCE, 0, 0, 0, 0);
        set_grid(5'd3, 5'd5, 5'd2);
        random_phase(150);
        set_grid(5'd0, 5'd31, 5'd17);
        random_phase(150);

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (n_fail == 0 && pending_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
